// ----- rtl/box_average_downscaler_defines.svh -----
// assertion macros for the box average downscaler
// no dependencies; included by the top level
`ifndef BOX_AVERAGE_DOWNSCALER_DEFINES_SVH
`define BOX_AVERAGE_DOWNSCALER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BAD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BAD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define BAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/bad_pkg.sv -----
// shared types and constants of the box average downscaler
// no dependencies
package bad_pkg;
    localparam int PIX_W        = 8;
    localparam int COORD_W      = 12;
    localparam int ZOOM_W       = 5;
    localparam int DIM_W        = 13;
    localparam int CFG_W        = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int ROW_W        = 12;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int QUOT_W       = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACC,
        S_DIV
    } t_state;
endpackage

// ----- rtl/bad_line_store.sv -----
// line store of per-column partial block sums, one read and one write port
// depends on nothing but its parameters
module bad_line_store #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 48
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);
    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- rtl/bad_divider.sv -----
// three-channel restoring divider for rounded block means, one quotient bit a cycle
// uses bad_pkg
module bad_divider #(
    parameter int SUM_W = 16,
    parameter int CNT_W = 9
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [2:0][SUM_W-1:0]           i_sum,
    input  logic [CNT_W-1:0]                i_count,
    output logic                            o_done,
    output logic [2:0][bad_pkg::QUOT_W-1:0] o_quot
);
    import bad_pkg::*;

    localparam int DV_W = CNT_W + 9;
    localparam int STEP_W = $clog2(QUOT_W);

    logic [2:0][DV_W-1:0]   r_rem, n_rem;
    logic [2:0][QUOT_W-1:0] r_quot, n_quot;
    logic [DV_W-1:0]        r_den;
    logic [STEP_W-1:0]      r_step;
    logic                   r_busy, r_done;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r_rem[c] >= r_den) begin
                n_rem[c]  = r_rem[c] - r_den;
                n_quot[c] = {r_quot[c][QUOT_W-2:0], 1'b1};
            end else begin
                n_rem[c]  = r_rem[c];
                n_quot[c] = {r_quot[c][QUOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(QUOT_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // dividend 2*sum+count, divisor 2*count aligned to the top quotient bit
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            for (int c = 0; c < 3; c++) begin
                r_rem[c]  <= (DV_W'(i_sum[c]) << 1) + DV_W'(i_count);
                r_quot[c] <= '0;
            end
            r_den <= DV_W'(i_count) << QUOT_W;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
            r_den  <= r_den >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ----- rtl/box_average_downscaler.sv -----
// box average downscaler: each pixel is taken in idle (line store read), then
// written back; the last pixel of a block also runs the 8-step mean divider
// the line store update holds off the next pixel; the divider sets the block cost
// a finished mean waits in the output register while the next pixel is taken
// synchronous active-low reset clears the position counters, the registers to
// zoom 1 and 4096 by 4096, and the output valid; the line store is not cleared
`include "box_average_downscaler_defines.svh"
module box_average_downscaler #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_ZOOM  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration writes
    input  logic                            i_cfg_wr_en,
    input  logic [bad_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bad_pkg::CFG_W-1:0]       i_cfg_data,
    // pixel request channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [bad_pkg::PIX_W-1:0]       i_red_in,
    input  logic [bad_pkg::PIX_W-1:0]       i_green_in,
    input  logic [bad_pkg::PIX_W-1:0]       i_blue_in,
    // averaged pixel request channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [bad_pkg::PIX_W-1:0]       o_red_avg,
    output logic [bad_pkg::PIX_W-1:0]       o_green_avg,
    output logic [bad_pkg::PIX_W-1:0]       o_blue_avg,
    output logic [bad_pkg::COORD_W-1:0]     o_out_x,
    output logic [bad_pkg::COORD_W-1:0]     o_out_y,
    output logic                            o_frame_end
);
    import bad_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = (COL_W + 1 > DIM_W + 1) ? COL_W + 1 : DIM_W + 1;
    localparam int ZB_W  = $clog2(MAX_ZOOM + 1);
    localparam int CNT_W = $clog2(MAX_ZOOM * MAX_ZOOM + 1);
    localparam int SUM_W = PIX_W + $clog2(MAX_ZOOM * MAX_ZOOM);

    // configuration registers
    logic [ZOOM_W-1:0] r_zoom;
    logic [DIM_W-1:0]  r_width, r_height;

    // raster position
    logic [COL_W-1:0] r_in_col, n_in_col, r_blk_col, n_blk_col;
    logic [ROW_W-1:0] r_in_row, n_in_row, r_blk_row, n_blk_row;
    logic [ZB_W-1:0]  r_cib, n_cib, r_rib, n_rib;

    // pixel in flight
    logic [2:0][PIX_W-1:0] r_pix;
    logic [COL_W-1:0]      r_bx;
    logic [ROW_W-1:0]      r_by;
    logic [CNT_W-1:0]      r_count;
    logic                  r_first, r_last_blk, r_fend;

    // output register
    logic                  r_out_valid;
    logic [2:0][PIX_W-1:0] r_out_avg;
    logic [COORD_W-1:0]    r_out_x, r_out_y;
    logic                  r_out_fend;

    t_state r_state, n_state;

    logic [ZB_W-1:0]  z;
    logic [CMP_W-1:0] w, h;
    logic             last_col, last_row, accept, out_load, div_start, wr_en;

    logic [3*SUM_W-1:0]    rd_data, wr_data;
    logic [2:0][SUM_W-1:0] new_sum;
    logic                  div_done;
    logic [2:0][QUOT_W-1:0] div_quot;

    // clamp the registers to their legal ranges
    always_comb begin
        if (r_zoom == '0) begin
            z = ZB_W'(1);
        end else if (r_zoom > MAX_ZOOM) begin
            z = ZB_W'(MAX_ZOOM);
        end else begin
            z = ZB_W'(r_zoom);
        end
        if (r_width == '0) begin
            w = CMP_W'(1);
        end else if (r_width > MAX_WIDTH) begin
            w = CMP_W'(MAX_WIDTH);
        end else begin
            w = CMP_W'(r_width);
        end
        if (r_height == '0) begin
            h = CMP_W'(1);
        end else if (r_height > HEIGHT_LIMIT) begin
            h = CMP_W'(HEIGHT_LIMIT);
        end else begin
            h = CMP_W'(r_height);
        end
    end

    assign last_col = ((ZB_W+1)'(r_cib) + 1'b1 == {1'b0, z}) ||
                      (CMP_W'(r_in_col) + 1'b1 >= w);
    assign last_row = ((ZB_W+1)'(r_rib) + 1'b1 == {1'b0, z}) ||
                      (CMP_W'(r_in_row) + 1'b1 >= h);

    assign accept = i_valid && o_ready;

    // next raster position
    always_comb begin
        n_in_col  = r_in_col;
        n_blk_col = r_blk_col;
        n_cib     = r_cib;
        n_in_row  = r_in_row;
        n_blk_row = r_blk_row;
        n_rib     = r_rib;
        if (CMP_W'(r_in_col) + 1'b1 >= w) begin
            n_in_col  = '0;
            n_cib     = '0;
            n_blk_col = '0;
            if (CMP_W'(r_in_row) + 1'b1 >= h) begin
                n_in_row  = '0;
                n_rib     = '0;
                n_blk_row = '0;
            end else begin
                n_in_row = r_in_row + 1'b1;
                if ((ZB_W+1)'(r_rib) + 1'b1 >= {1'b0, z}) begin
                    n_rib     = '0;
                    n_blk_row = r_blk_row + 1'b1;
                end else begin
                    n_rib = r_rib + 1'b1;
                end
            end
        end else begin
            n_in_col = r_in_col + 1'b1;
            if ((ZB_W+1)'(r_cib) + 1'b1 >= {1'b0, z}) begin
                n_cib     = '0;
                n_blk_col = r_blk_col + 1'b1;
            end else begin
                n_cib = r_cib + 1'b1;
            end
        end
    end

    // config registers and position; a write to zoom, width or height restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zoom    <= ZOOM_W'(1);
            r_width   <= DIM_W'(4096);
            r_height  <= DIM_W'(4096);
            r_in_col  <= '0;
            r_blk_col <= '0;
            r_cib     <= '0;
            r_in_row  <= '0;
            r_blk_row <= '0;
            r_rib     <= '0;
        end else if (i_cfg_wr_en && (i_cfg_idx == CFG_ZOOM || i_cfg_idx == CFG_WIDTH ||
                                     i_cfg_idx == CFG_HEIGHT)) begin
            case (i_cfg_idx)
                CFG_ZOOM:   r_zoom   <= i_cfg_data[ZOOM_W-1:0];
                CFG_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                default:    r_zoom   <= r_zoom;
            endcase
            r_in_col  <= '0;
            r_blk_col <= '0;
            r_cib     <= '0;
            r_in_row  <= '0;
            r_blk_row <= '0;
            r_rib     <= '0;
        end else if (accept) begin
            r_in_col  <= n_in_col;
            r_blk_col <= n_blk_col;
            r_cib     <= n_cib;
            r_in_row  <= n_in_row;
            r_blk_row <= n_blk_row;
            r_rib     <= n_rib;
        end
    end

    // capture the pixel and its block bookkeeping
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix      <= {i_blue_in, i_green_in, i_red_in};
            r_bx       <= r_blk_col;
            r_by       <= r_blk_row;
            r_first    <= (r_cib == '0) && (r_rib == '0);
            r_last_blk <= last_col && last_row;
            r_count    <= (CNT_W'(r_cib) + 1'b1) * (CNT_W'(r_rib) + 1'b1);
            r_fend     <= (CMP_W'(r_in_col) + 1'b1 >= w) && (CMP_W'(r_in_row) + 1'b1 >= h);
        end
    end

    // read-modify-write of the column sum; the first pixel of a block overwrites
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r_first) begin
                new_sum[c] = SUM_W'(r_pix[c]);
            end else begin
                new_sum[c] = rd_data[c*SUM_W +: SUM_W] + SUM_W'(r_pix[c]);
            end
        end
    end
    assign wr_data = new_sum;

    bad_line_store #(
        .ADDR_W (COL_W),
        .DATA_W (3 * SUM_W)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_blk_col),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_bx),
        .i_wr_data (wr_data)
    );

    bad_divider #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (new_sum),
        .i_count (r_count),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = S_ACC;
            S_ACC:  n_state = r_last_blk ? S_DIV : S_IDLE;
            S_DIV:  if (div_done && (!r_out_valid || i_ready)) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_ready   = 1'b0;
        wr_en     = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: o_ready = 1'b1;
            S_ACC: begin
                wr_en     = 1'b1;
                div_start = r_last_blk;
            end
            S_DIV:  out_load = div_done && (!r_out_valid || i_ready);
            default: o_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_avg  <= div_quot;
            r_out_x    <= COORD_W'(r_bx);
            r_out_y    <= COORD_W'(r_by);
            r_out_fend <= r_fend;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_red_avg   = r_out_avg[0];
    assign o_green_avg = r_out_avg[1];
    assign o_blue_avg  = r_out_avg[2];
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_frame_end = r_out_fend;

    // a new mean shows only after the divider finished
    `BAD_ASSERT_SAME(a_out_from_div, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_DIV && div_done), "output valid rose without a finished mean")
    // a finished mean with a free output register is loaded at once
    `BAD_ASSERT_NEXT(a_div_drains, i_clk, i_rst_n, r_state == S_DIV && div_done && !r_out_valid, o_valid && r_state == S_IDLE, "finished mean not loaded")
    // a pixel is never taken while the line store update or the mean division is pending
    `BAD_ASSERT_SAME(a_no_take_busy, i_clk, i_rst_n, r_state == S_ACC || r_state == S_DIV, !o_ready, "pixel taken during update")
endmodule
